// File: design/rot90_pkg.sv
`default_nettype none

package rot90_pkg;

    localparam int DEF_MAX_DIM    = 256;
    localparam int DEF_MAX_PIXELS = 65536;

    localparam int PIX_W      = 24;
    localparam int CFG_DIM_W  = 9;
    localparam int CFG_AW     = 4;
    localparam int CFG_DW     = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TURN_RIGHT = 2'd2;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [1:0] SETTLE_CYCLES = 2'd2;

    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             last;
    } out_item_t;

    typedef struct packed {
        logic turn_right;
        logic restart;
    } rot90_ctl_t;

endpackage

`default_nettype wire

// File: design/rot90_ram.sv
`default_nettype none

module rot90_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: design/rot90_cfg.sv
`default_nettype none

module rot90_cfg import rot90_pkg::*; #(
    parameter int MAX_DIM = DEF_MAX_DIM,
    parameter int DIM_W   = $clog2(DEF_MAX_DIM + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready,
    output logic      [DIM_W-1:0]  dim_w,
    output logic      [DIM_W-1:0]  dim_h,
    output rot90_ctl_t             ctl
);

    localparam int CMP_W = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;
    localparam logic [CMP_W-1:0] MAX_DIM_C = CMP_W'(MAX_DIM);

    logic [CFG_DIM_W-1:0] src_width_reg;
    logic [CFG_DIM_W-1:0] src_height_reg;
    logic                 turn_right_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    logic                 wr_hit;

    function automatic logic [DIM_W-1:0] dim_clamp(input logic [CFG_DIM_W-1:0] v);
        logic [CMP_W-1:0] vx;
        vx = CMP_W'(v);
        if (vx == '0) begin
            return DIM_W'(1);
        end else if (vx > MAX_DIM_C) begin
            return DIM_W'(MAX_DIM_C);
        end
        return DIM_W'(vx);
    endfunction

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_AW-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        wr_hit = 1'b0;
        prdata = '0;
        case (reg_idx)
            REG_SRC_WIDTH: begin
                wr_hit = wr_en;
                prdata = CFG_DW'(src_width_reg);
            end
            REG_SRC_HEIGHT: begin
                wr_hit = wr_en;
                prdata = CFG_DW'(src_height_reg);
            end
            REG_TURN_RIGHT: begin
                wr_hit = wr_en;
                prdata = CFG_DW'(turn_right_reg);
            end
            default: begin
                wr_hit = 1'b0;
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= CFG_DIM_W'(1);
            src_height_reg <= CFG_DIM_W'(1);
            turn_right_reg <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SRC_WIDTH:  src_width_reg  <= pwdata[CFG_DIM_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= pwdata[CFG_DIM_W-1:0];
                REG_TURN_RIGHT: turn_right_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    assign dim_w          = dim_clamp(src_width_reg);
    assign dim_h          = dim_clamp(src_height_reg);
    assign ctl.turn_right = turn_right_reg;
    assign ctl.restart    = wr_hit;

endmodule

`default_nettype wire

// File: design/rot90_agen.sv
`default_nettype none

module rot90_agen import rot90_pkg::*; #(
    parameter int DIM_W = $clog2(DEF_MAX_DIM + 1),
    parameter int TOT_W = $clog2(DEF_MAX_DIM * DEF_MAX_DIM + 1)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [DIM_W-1:0] dim_w,
    input  wire logic [DIM_W-1:0] dim_h,
    input  rot90_ctl_t            ctl,
    input  wire logic             load_step,
    input  wire logic             read_step,
    output logic                  ready,
    output logic      [TOT_W-1:0] ld_addr,
    output logic      [TOT_W-1:0] rd_addr,
    output logic                  rd_last
);

    logic [1:0]       settle_reg;
    logic [TOT_W-1:0] total_reg;
    logic [DIM_W-1:0] col_reg;
    logic [DIM_W-1:0] row_reg;
    logic [TOT_W-1:0] base_reg;
    logic [TOT_W-1:0] addr_reg;
    logic [TOT_W-1:0] idx_reg;

    logic [TOT_W-1:0] hx;
    logic [TOT_W-1:0] base_first;
    logic [TOT_W-1:0] base_step;
    logic [TOT_W-1:0] col_step;
    logic             col_last;
    logic             row_last;

    assign hx         = TOT_W'(dim_h);
    assign base_first = ctl.turn_right ? (total_reg - hx) : (hx - TOT_W'(1));
    assign base_step  = ctl.turn_right ? (base_reg + TOT_W'(1)) : (base_reg - TOT_W'(1));
    assign col_step   = ctl.turn_right ? (addr_reg - hx) : (addr_reg + hx);
    assign col_last   = (col_reg == dim_w - DIM_W'(1));
    assign row_last   = (row_reg == dim_h - DIM_W'(1));

    assign ready   = (settle_reg == '0);
    assign ld_addr = addr_reg;
    assign rd_addr = idx_reg;
    assign rd_last = (idx_reg == total_reg - TOT_W'(1));

    always_ff @(posedge aclk) begin
        total_reg <= TOT_W'(dim_w) * TOT_W'(dim_h);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg <= SETTLE_CYCLES;
        end else if (ctl.restart) begin
            settle_reg <= SETTLE_CYCLES;
        end else if (settle_reg != '0) begin
            settle_reg <= settle_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            base_reg <= '0;
            addr_reg <= '0;
            idx_reg  <= '0;
        end else if (settle_reg == 2'd1) begin
            col_reg  <= '0;
            row_reg  <= '0;
            base_reg <= base_first;
            addr_reg <= base_first;
            idx_reg  <= '0;
        end else begin
            if (load_step) begin
                if (col_last) begin
                    col_reg <= '0;
                    if (row_last) begin
                        row_reg  <= '0;
                        base_reg <= base_first;
                        addr_reg <= base_first;
                    end else begin
                        row_reg  <= row_reg + DIM_W'(1);
                        base_reg <= base_step;
                        addr_reg <= base_step;
                    end
                end else begin
                    col_reg  <= col_reg + DIM_W'(1);
                    addr_reg <= col_step;
                end
            end
            if (read_step) begin
                idx_reg <= rd_last ? '0 : (idx_reg + TOT_W'(1));
            end
        end
    end

endmodule

`default_nettype wire

// File: design/image_rotate_90_frame_engine_top.sv
// Channel   | Direction | Handshake        | Payload
// s_        | in        | s_valid/s_ready  | in_item_t  {kind, pixel_in}
// m_        | out       | m_valid/m_ready  | out_item_t {pixel_out, last}
// APB       | in        | psel/penable     | src_width, src_height, turn_right
//
// Load requests may follow back to back.
// A read request passes through address, registered frame memory read and output
// register; one read is in flight at a time and s_ready stays low until its result
// is taken. m_ready low holds the result and stalls the input.
// After reset and after each register write s_ready is low while the frame size
// and the first load address are computed.
`default_nettype none

module image_rotate_90_frame_engine_top import rot90_pkg::*; #(
    parameter int MAX_DIM    = DEF_MAX_DIM,
    parameter int MAX_PIXELS = DEF_MAX_PIXELS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_item_t              m_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready
);

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int TOT_W  = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam int MEM_AW = $clog2(MAX_PIXELS);

    logic [DIM_W-1:0]  dim_w;
    logic [DIM_W-1:0]  dim_h;
    rot90_ctl_t        ctl;
    logic              agen_ready;
    logic [TOT_W-1:0]  ld_addr;
    logic [TOT_W-1:0]  rd_addr;
    logic              rd_last;
    logic              s_accept;
    logic              load_step;
    logic              read_step;
    logic              ld_hit;
    logic              rd_hit;
    logic [PIX_W-1:0]  rdata;

    logic              rd_pend_reg;
    logic              pend_last_reg;
    logic              pend_hit_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    rot90_cfg #(
        .MAX_DIM (MAX_DIM),
        .DIM_W   (DIM_W)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .dim_w   (dim_w),
        .dim_h   (dim_h),
        .ctl     (ctl)
    );

    rot90_agen #(
        .DIM_W (DIM_W),
        .TOT_W (TOT_W)
    ) u_agen (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .dim_w     (dim_w),
        .dim_h     (dim_h),
        .ctl       (ctl),
        .load_step (load_step),
        .read_step (read_step),
        .ready     (agen_ready),
        .ld_addr   (ld_addr),
        .rd_addr   (rd_addr),
        .rd_last   (rd_last)
    );

    assign s_ready   = agen_ready && !rd_pend_reg && !m_valid_reg;
    assign s_accept  = s_valid && s_ready;
    assign load_step = s_accept && (s_data.kind == KIND_LOAD);
    assign read_step = s_accept && (s_data.kind == KIND_READ);
    assign ld_hit    = 32'(ld_addr) < 32'(MAX_PIXELS);
    assign rd_hit    = 32'(rd_addr) < 32'(MAX_PIXELS);

    rot90_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_PIXELS)
    ) u_frame (
        .aclk  (aclk),
        .we    (load_step && ld_hit),
        .waddr (MEM_AW'(ld_addr)),
        .wdata (s_data.pixel_in),
        .re    (read_step),
        .raddr (MEM_AW'(rd_addr)),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            rd_pend_reg <= read_step;
            if (rd_pend_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (read_step) begin
            pend_last_reg <= rd_last;
            pend_hit_reg  <= rd_hit;
        end
        if (rd_pend_reg) begin
            m_data_reg.pixel_out <= pend_hit_reg ? rdata : '0;
            m_data_reg.last      <= pend_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// File: design/rot90_chk.sv
`default_nettype none

module rot90_chk import rot90_pkg::*; (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input in_item_t               s_data,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input out_item_t              m_data,
    input wire logic              psel,
    input wire logic              penable,
    input wire logic              pwrite,
    input wire logic [CFG_AW-1:0] paddr,
    input wire logic              pready
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    a_read_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.kind == KIND_READ) |-> ##2 m_valid)
        else $error("read request gave no result");

    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.kind == KIND_LOAD) && !m_valid |=> !m_valid)
        else $error("load request produced a result");

    a_single_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("request taken while a result is pending");

    a_cfg_settle: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && pready
            && (paddr[CFG_AW-1:2] <= REG_TURN_RIGHT) |=> !s_ready)
        else $error("request taken right after a register write");

endmodule

bind image_rotate_90_frame_engine_top rot90_chk u_chk (.*);

`default_nettype wire
